@@ rtl/vtv_pkg.sv @@
// vtv_pkg: shared constants, types and helpers for the vertex transform and viewport block
package vtv_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int WORD_W     = 32;
   localparam int DIM_W      = 14;
   localparam int PROD_W     = 2 * WORD_W;
   localparam int NUM_W      = WORD_W + DIM_W + 1;
   localparam int MAG_W      = NUM_W - 1;
   localparam int DEN_W      = WORD_W + 1;
   localparam int VQ_BITS    = ((FRAC_BITS + DIM_W > WORD_W) ? FRAC_BITS + DIM_W : WORD_W) + 1;
   localparam int DIV_W      = DEN_W + VQ_BITS + 1;
   localparam int SQRT_STEPS = WORD_W;
   localparam int SQ_W       = PROD_W;
   localparam int SAT_W      = (PROD_W + 2 > VQ_BITS + 3) ? PROD_W + 2 : VQ_BITS + 3;
   localparam int MAT_N      = 16;
   localparam int IDX_W      = 4;
   localparam int REQ_DATA_W = 264;
   localparam int RSP_DATA_W = 7 * WORD_W;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(1024);
   localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(768);

   typedef enum logic [1:0] {
      KIND_VERTEX    = 2'd0,
      KIND_LOAD_PROJ = 2'd1,
      KIND_LOAD_NORM = 2'd2,
      KIND_UNUSED    = 2'd3
   } kind_type;

   typedef enum logic {
      REG_SCREEN_WIDTH  = 1'b0,
      REG_SCREEN_HEIGHT = 1'b1
   } csr_reg_type;

   // values that ride along the long sqrt and divide stages
   typedef struct packed {
      logic [WORD_W-1:0]       clip_z;
      logic [WORD_W-1:0]       clip_w;
      logic                    w_zero;
      logic                    nneg_x;
      logic                    nneg_y;
      logic                    qneg_x;
      logic                    qneg_y;
      logic                    ovf_x;
      logic                    ovf_y;
      logic [2:0]              tneg;
      logic [2:0][WORD_W-1:0]  tmag;
      logic [MAG_W-1:0]        nmag_x;
      logic [MAG_W-1:0]        nmag_y;
      logic [DEN_W-1:0]        den;
   } carry_type;

   function automatic logic [WORD_W-1:0] sat_word(input logic signed [SAT_W-1:0] v);
      logic [SAT_W-WORD_W:0] top;
      top = v[SAT_W-1:WORD_W-1];
      if (&top || ~|top) begin
         sat_word = v[WORD_W-1:0];
      end else if (v[SAT_W-1]) begin
         sat_word = {1'b1, {(WORD_W-1){1'b0}}};
      end else begin
         sat_word = {1'b0, {(WORD_W-1){1'b1}}};
      end
   endfunction

endpackage

@@ rtl/vertex_transform_viewport.sv @@
// vertex_transform_viewport: matrix transform, viewport divide and normal normalize pipeline
//
//  port group  dir   beat contents
//  req_*       in    tuser: kind; tdata: entry_index, entry_value, position x/y/z/w, normal x/y/z
//  rsp_*       out   tuser: w_zero; tdata: screen x/y, clip z/w, world normal x/y/z
//  csr_*       in    register 0 screen_width, register 1 screen_height, one word each
//
// one beat per cycle in and out while the output is not held; the square root yields one
// result bit per stage and the restoring divide one quotient bit per stage.
// load beats write the matrix on acceptance and make no result.
// the whole pipe holds while a result waits at the output; nothing is dropped or repeated.
// reset clears both matrices and the valid bits and sets the viewport registers to 1024 by 768.
module vertex_transform_viewport (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // entry_index, entry_value, position_x/y/z/w, normal_x/y/z (lowest first), zero pad
   input  logic [vtv_pkg::REQ_DATA_W-1:0]      req_tdata,
   // kind
   input  logic [1:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // screen_x, screen_y, clip_z, clip_w, world_normal_x/y/z (lowest first)
   output logic [vtv_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // w_zero
   output logic [0:0]                          rsp_tuser,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [vtv_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [vtv_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [vtv_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   // configuration
   logic [vtv_pkg::DIM_W-1:0] width_ff, width_in, height_ff, height_in;
   logic                      csr_wr;

   // matrices
   logic signed [vtv_pkg::WORD_W-1:0] proj_ff [vtv_pkg::MAT_N];
   logic signed [vtv_pkg::WORD_W-1:0] proj_in [vtv_pkg::MAT_N];
   logic signed [vtv_pkg::WORD_W-1:0] norm_ff [vtv_pkg::MAT_N];
   logic signed [vtv_pkg::WORD_W-1:0] norm_in [vtv_pkg::MAT_N];

   logic adv, req_acc;
   logic [vtv_pkg::IDX_W-1:0]  req_index;
   logic [vtv_pkg::WORD_W-1:0] req_value;

   // stage 0: input
   logic s0_v_ff, s0_v_in;
   logic signed [vtv_pkg::WORD_W-1:0] s0_pos_ff [4], s0_pos_in [4];
   logic signed [vtv_pkg::WORD_W-1:0] s0_nrm_ff [3], s0_nrm_in [3];
   // stage 1: products
   logic s1_v_ff;
   logic signed [vtv_pkg::PROD_W-1:0] s1_pp_ff [16], s1_pp_in [16];
   logic signed [vtv_pkg::PROD_W-1:0] s1_np_ff [9], s1_np_in [9];
   // stage 2: pair sums
   logic s2_v_ff;
   logic signed [vtv_pkg::PROD_W:0]   s2_ps_ff [8], s2_ps_in [8];
   logic signed [vtv_pkg::PROD_W:0]   s2_na_ff [3], s2_na_in [3];
   logic signed [vtv_pkg::PROD_W-1:0] s2_nb_ff [3], s2_nb_in [3];
   // stage 3: row results
   logic s3_v_ff;
   logic signed [vtv_pkg::WORD_W-1:0] s3_clip_ff [4], s3_clip_in [4];
   logic signed [vtv_pkg::WORD_W-1:0] s3_tn_ff [3], s3_tn_in [3];
   // stage 4: viewport scale and squares
   logic s4_v_ff;
   logic signed [vtv_pkg::NUM_W-1:0]  s4_nx_ff, s4_nx_in, s4_ny_ff, s4_ny_in;
   logic signed [vtv_pkg::PROD_W-1:0] s4_sq_ff [3], s4_sq_in [3];
   logic signed [vtv_pkg::WORD_W-1:0] s4_cz_ff, s4_cz_in, s4_cw_ff, s4_cw_in;
   logic signed [vtv_pkg::WORD_W-1:0] s4_tn_ff [3], s4_tn_in [3];
   logic s4_wz_ff, s4_wz_in;
   // stage 5: magnitudes, sum of squares
   logic s5_v_ff;
   vtv_pkg::carry_type s5_c_ff, s5_c_in;
   logic [vtv_pkg::SQ_W-1:0] s5_ssum_ff, s5_ssum_in;
   // stage 6: quotient overflow check
   logic s6_v_ff;
   vtv_pkg::carry_type s6_c_ff, s6_c_in;
   logic [vtv_pkg::SQ_W-1:0] s6_ssum_ff;

   // square root stages
   logic                     sq_v_ff   [vtv_pkg::SQRT_STEPS];
   vtv_pkg::carry_type       sq_c_ff   [vtv_pkg::SQRT_STEPS];
   vtv_pkg::carry_type       sq_c_in   [vtv_pkg::SQRT_STEPS];
   logic [vtv_pkg::SQ_W-1:0] sq_rem_ff [vtv_pkg::SQRT_STEPS];
   logic [vtv_pkg::SQ_W-1:0] sq_rem_in [vtv_pkg::SQRT_STEPS];
   logic [vtv_pkg::SQ_W-1:0] sq_res_ff [vtv_pkg::SQRT_STEPS];
   logic [vtv_pkg::SQ_W-1:0] sq_res_in [vtv_pkg::SQRT_STEPS];

   // divide stages
   logic                        dv_v_ff   [vtv_pkg::VQ_BITS];
   vtv_pkg::carry_type          dv_c_ff   [vtv_pkg::VQ_BITS];
   vtv_pkg::carry_type          dv_c_in   [vtv_pkg::VQ_BITS];
   logic [vtv_pkg::WORD_W-1:0]  dv_len_ff [vtv_pkg::VQ_BITS];
   logic [vtv_pkg::WORD_W-1:0]  dv_len_in [vtv_pkg::VQ_BITS];
   logic [vtv_pkg::DIV_W-1:0]   dv_rem_ff [vtv_pkg::VQ_BITS][5];
   logic [vtv_pkg::DIV_W-1:0]   dv_rem_in [vtv_pkg::VQ_BITS][5];
   logic [vtv_pkg::VQ_BITS-1:0] dv_q_ff   [vtv_pkg::VQ_BITS][5];
   logic [vtv_pkg::VQ_BITS-1:0] dv_q_in   [vtv_pkg::VQ_BITS][5];

   // output register
   logic out_valid_ff;
   logic [vtv_pkg::RSP_DATA_W-1:0] out_data_ff, out_data_in;
   logic out_flag_ff, out_flag_in;

   assign adv        = !out_valid_ff || rsp_tready;
   assign req_tready = adv;
   assign req_acc    = req_tvalid && adv;
   assign req_index  = req_tdata[3:0];
   assign req_value  = req_tdata[35:4];

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = out_data_ff;
   assign rsp_tuser[0] = out_flag_ff;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_wr) begin
         case (vtv_pkg::csr_reg_type'(csr_paddr[2]))
            vtv_pkg::REG_SCREEN_WIDTH:  width_in  = csr_pwdata[vtv_pkg::DIM_W-1:0];
            vtv_pkg::REG_SCREEN_HEIGHT: height_in = csr_pwdata[vtv_pkg::DIM_W-1:0];
            default: ;
         endcase
      end
      case (vtv_pkg::csr_reg_type'(csr_paddr[2]))
         vtv_pkg::REG_SCREEN_WIDTH:
            csr_prdata = vtv_pkg::CSR_DATA_W'(width_ff);
         vtv_pkg::REG_SCREEN_HEIGHT:
            csr_prdata = vtv_pkg::CSR_DATA_W'(height_ff);
         default:
            csr_prdata = '0;
      endcase
   end

   // matrix loads land at acceptance, so later vertices see them in order
   always_comb begin
      for (int e = 0; e < vtv_pkg::MAT_N; e++) begin
         proj_in[e] = proj_ff[e];
         norm_in[e] = norm_ff[e];
      end
      if (req_acc) begin
         case (req_tuser)
            vtv_pkg::KIND_LOAD_PROJ: proj_in[req_index] = req_value;
            vtv_pkg::KIND_LOAD_NORM: norm_in[req_index] = req_value;
            default: ;
         endcase
      end
   end

   // front stages
   always_comb begin
      logic signed [vtv_pkg::PROD_W+1:0] tot;
      logic signed [vtv_pkg::SAT_W-1:0]  ext;
      logic signed [vtv_pkg::DIM_W:0]    wdim, hdim;
      logic signed [vtv_pkg::NUM_W-1:0]  nneg;
      logic [vtv_pkg::WORD_W-1:0]        wabs;

      s0_v_in = req_tvalid && (req_tuser == vtv_pkg::KIND_VERTEX);
      for (int c = 0; c < 4; c++) begin
         s0_pos_in[c] = req_tdata[36 + 32*c +: 32];
      end
      for (int c = 0; c < 3; c++) begin
         s0_nrm_in[c] = req_tdata[164 + 32*c +: 32];
      end

      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            s1_pp_in[r*4+c] = proj_ff[r*4+c] * s0_pos_ff[c];
         end
      end
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            s1_np_in[r*3+c] = norm_ff[r*4+c] * s0_nrm_ff[c];
         end
      end

      for (int r = 0; r < 4; r++) begin
         s2_ps_in[2*r]   = s1_pp_ff[4*r]   + s1_pp_ff[4*r+1];
         s2_ps_in[2*r+1] = s1_pp_ff[4*r+2] + s1_pp_ff[4*r+3];
      end
      for (int r = 0; r < 3; r++) begin
         s2_na_in[r] = s1_np_ff[3*r] + s1_np_ff[3*r+1];
         s2_nb_in[r] = s1_np_ff[3*r+2];
      end

      // exact row sum, floor shift, saturate
      for (int r = 0; r < 4; r++) begin
         tot = s2_ps_ff[2*r] + s2_ps_ff[2*r+1];
         ext = tot;
         s3_clip_in[r] = vtv_pkg::sat_word(ext >>> vtv_pkg::FRAC_BITS);
      end
      for (int r = 0; r < 3; r++) begin
         tot = s2_na_ff[r] + s2_nb_ff[r];
         ext = tot;
         s3_tn_in[r] = vtv_pkg::sat_word(ext >>> vtv_pkg::FRAC_BITS);
      end

      wdim = {1'b0, width_ff};
      hdim = {1'b0, height_ff};
      s4_nx_in = s3_clip_ff[0] * wdim;
      s4_ny_in = s3_clip_ff[1] * hdim;
      for (int i = 0; i < 3; i++) begin
         s4_sq_in[i] = s3_tn_ff[i] * s3_tn_ff[i];
         s4_tn_in[i] = s3_tn_ff[i];
      end
      s4_cz_in = s3_clip_ff[2];
      s4_cw_in = s3_clip_ff[3];
      s4_wz_in = (s3_clip_ff[3] == '0);

      s5_c_in        = '0;
      s5_c_in.clip_z = s4_cz_ff;
      s5_c_in.clip_w = s4_cw_ff;
      s5_c_in.w_zero = s4_wz_ff;
      s5_c_in.nneg_x = s4_nx_ff[vtv_pkg::NUM_W-1];
      s5_c_in.nneg_y = s4_ny_ff[vtv_pkg::NUM_W-1];
      s5_c_in.qneg_x = s4_nx_ff[vtv_pkg::NUM_W-1] ^ s4_cw_ff[vtv_pkg::WORD_W-1];
      s5_c_in.qneg_y = s4_ny_ff[vtv_pkg::NUM_W-1] ^ s4_cw_ff[vtv_pkg::WORD_W-1];
      nneg = -s4_nx_ff;
      s5_c_in.nmag_x = s4_nx_ff[vtv_pkg::NUM_W-1] ? nneg[vtv_pkg::MAG_W-1:0]
                                                   : s4_nx_ff[vtv_pkg::MAG_W-1:0];
      nneg = -s4_ny_ff;
      s5_c_in.nmag_y = s4_ny_ff[vtv_pkg::NUM_W-1] ? nneg[vtv_pkg::MAG_W-1:0]
                                                   : s4_ny_ff[vtv_pkg::MAG_W-1:0];
      wabs = s4_cw_ff[vtv_pkg::WORD_W-1] ? -s4_cw_ff : s4_cw_ff;
      s5_c_in.den = {wabs, 1'b0};
      for (int i = 0; i < 3; i++) begin
         s5_c_in.tneg[i] = s4_tn_ff[i][vtv_pkg::WORD_W-1];
         s5_c_in.tmag[i] = s4_tn_ff[i][vtv_pkg::WORD_W-1] ? -s4_tn_ff[i] : s4_tn_ff[i];
      end
      s5_ssum_in = s4_sq_ff[0] + s4_sq_ff[1] + s4_sq_ff[2];
   end

   // quotient too large for the VQ_BITS quotient bits of the divide stages
   always_comb begin
      logic [vtv_pkg::DIV_W-1:0] dlim;
      dlim = vtv_pkg::DIV_W'(s5_c_ff.den) << vtv_pkg::VQ_BITS;
      s6_c_in = s5_c_ff;
      s6_c_in.ovf_x =
         vtv_pkg::DIV_W'({s5_c_ff.nmag_x, {vtv_pkg::FRAC_BITS{1'b0}}}) >= dlim;
      s6_c_in.ovf_y =
         vtv_pkg::DIV_W'({s5_c_ff.nmag_y, {vtv_pkg::FRAC_BITS{1'b0}}}) >= dlim;
   end

   // integer square root, one result bit per stage
   always_comb begin
      logic [vtv_pkg::SQ_W-1:0] rem_s, res_s;
      logic [vtv_pkg::SQ_W:0]   bitc, trial;
      vtv_pkg::carry_type       c_s;
      for (int j = 0; j < vtv_pkg::SQRT_STEPS; j++) begin
         if (j == 0) begin
            rem_s = s6_ssum_ff;
            res_s = '0;
            c_s   = s6_c_ff;
         end else begin
            rem_s = sq_rem_ff[(j == 0) ? 0 : j-1];
            res_s = sq_res_ff[(j == 0) ? 0 : j-1];
            c_s   = sq_c_ff[(j == 0) ? 0 : j-1];
         end
         bitc  = (vtv_pkg::SQ_W+1)'(1) << (2*(vtv_pkg::SQRT_STEPS-1-j));
         trial = {1'b0, res_s} + bitc;
         if ({1'b0, rem_s} >= trial) begin
            sq_rem_in[j] = rem_s - trial[vtv_pkg::SQ_W-1:0];
            sq_res_in[j] = (res_s >> 1) + bitc[vtv_pkg::SQ_W-1:0];
         end else begin
            sq_rem_in[j] = rem_s;
            sq_res_in[j] = res_s >> 1;
         end
         sq_c_in[j] = c_s;
      end
   end

   // restoring divide, one quotient bit per stage, five lanes:
   // screen x, screen y, normal x, normal y, normal z
   always_comb begin
      logic [vtv_pkg::DIV_W-1:0]   rem_s [5];
      logic [vtv_pkg::VQ_BITS-1:0] q_s [5];
      logic [vtv_pkg::DIV_W-1:0]   dsh, lsh;
      logic [vtv_pkg::WORD_W-1:0]  len_s;
      vtv_pkg::carry_type          c_s;
      int                          k;
      for (int i = 0; i < vtv_pkg::VQ_BITS; i++) begin
         if (i == 0) begin
            c_s      = sq_c_ff[vtv_pkg::SQRT_STEPS-1];
            len_s    = sq_res_ff[vtv_pkg::SQRT_STEPS-1][vtv_pkg::WORD_W-1:0];
            rem_s[0] = vtv_pkg::DIV_W'({c_s.nmag_x, {vtv_pkg::FRAC_BITS{1'b0}}});
            rem_s[1] = vtv_pkg::DIV_W'({c_s.nmag_y, {vtv_pkg::FRAC_BITS{1'b0}}});
            for (int n = 0; n < 3; n++) begin
               rem_s[2+n] = vtv_pkg::DIV_W'({c_s.tmag[n], {vtv_pkg::FRAC_BITS{1'b0}}});
            end
            for (int n = 0; n < 5; n++) begin
               q_s[n] = '0;
            end
         end else begin
            c_s   = dv_c_ff[(i == 0) ? 0 : i-1];
            len_s = dv_len_ff[(i == 0) ? 0 : i-1];
            for (int n = 0; n < 5; n++) begin
               rem_s[n] = dv_rem_ff[(i == 0) ? 0 : i-1][n];
               q_s[n]   = dv_q_ff[(i == 0) ? 0 : i-1][n];
            end
         end
         k   = vtv_pkg::VQ_BITS - 1 - i;
         dsh = vtv_pkg::DIV_W'(c_s.den) << k;
         lsh = vtv_pkg::DIV_W'(len_s) << k;
         for (int n = 0; n < 5; n++) begin
            dv_rem_in[i][n] = rem_s[n];
            dv_q_in[i][n]   = q_s[n];
            if (rem_s[n] >= ((n < 2) ? dsh : lsh)) begin
               dv_rem_in[i][n]  = rem_s[n] - ((n < 2) ? dsh : lsh);
               dv_q_in[i][n][k] = 1'b1;
            end
         end
         dv_c_in[i]   = c_s;
         dv_len_in[i] = len_s;
      end
   end

   // sign, offset and saturate into the output register
   always_comb begin
      logic signed [vtv_pkg::SAT_W-1:0] qv, off, sum;
      logic [vtv_pkg::WORD_W-1:0]       sv [2];
      logic [vtv_pkg::WORD_W-1:0]       tv [3];
      logic [vtv_pkg::WORD_W-1:0]       qn;
      vtv_pkg::carry_type               c_s;
      logic                             nneg_s, qneg_s, ovf_s;
      c_s = dv_c_ff[vtv_pkg::VQ_BITS-1];
      for (int a = 0; a < 2; a++) begin
         nneg_s = (a == 0) ? c_s.nneg_x : c_s.nneg_y;
         qneg_s = (a == 0) ? c_s.qneg_x : c_s.qneg_y;
         ovf_s  = (a == 0) ? c_s.ovf_x : c_s.ovf_y;
         qv  = vtv_pkg::SAT_W'(dv_q_ff[vtv_pkg::VQ_BITS-1][a]);
         qv  = qneg_s ? -qv : qv;
         off = vtv_pkg::SAT_W'({((a == 0) ? width_ff : height_ff),
                                {(vtv_pkg::FRAC_BITS-1){1'b0}}});
         sum = qv + off;
         if (c_s.w_zero) begin
            sv[a] = nneg_s ? {1'b1, {(vtv_pkg::WORD_W-1){1'b0}}}
                           : {1'b0, {(vtv_pkg::WORD_W-1){1'b1}}};
         end else if (ovf_s) begin
            sv[a] = qneg_s ? {1'b1, {(vtv_pkg::WORD_W-1){1'b0}}}
                           : {1'b0, {(vtv_pkg::WORD_W-1){1'b1}}};
         end else begin
            sv[a] = vtv_pkg::sat_word(sum);
         end
      end
      // the unit normal never exceeds one, so no saturation is needed
      for (int n = 0; n < 3; n++) begin
         qn = dv_q_ff[vtv_pkg::VQ_BITS-1][2+n][vtv_pkg::WORD_W-1:0];
         if (dv_len_ff[vtv_pkg::VQ_BITS-1] == '0) begin
            tv[n] = '0;
         end else begin
            tv[n] = c_s.tneg[n] ? -qn : qn;
         end
      end
      out_data_in = {tv[2], tv[1], tv[0], c_s.clip_w, c_s.clip_z, sv[1], sv[0]};
      out_flag_in = c_s.w_zero;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= vtv_pkg::WIDTH_RESET;
         height_ff    <= vtv_pkg::HEIGHT_RESET;
         s0_v_ff      <= 1'b0;
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         s3_v_ff      <= 1'b0;
         s4_v_ff      <= 1'b0;
         s5_v_ff      <= 1'b0;
         s6_v_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int e = 0; e < vtv_pkg::MAT_N; e++) begin
            proj_ff[e] <= '0;
            norm_ff[e] <= '0;
         end
         for (int j = 0; j < vtv_pkg::SQRT_STEPS; j++) begin
            sq_v_ff[j] <= 1'b0;
         end
         for (int i = 0; i < vtv_pkg::VQ_BITS; i++) begin
            dv_v_ff[i] <= 1'b0;
         end
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         for (int e = 0; e < vtv_pkg::MAT_N; e++) begin
            proj_ff[e] <= proj_in[e];
            norm_ff[e] <= norm_in[e];
         end
         if (adv) begin
            s0_v_ff      <= s0_v_in;
            s1_v_ff      <= s0_v_ff;
            s2_v_ff      <= s1_v_ff;
            s3_v_ff      <= s2_v_ff;
            s4_v_ff      <= s3_v_ff;
            s5_v_ff      <= s4_v_ff;
            s6_v_ff      <= s5_v_ff;
            sq_v_ff[0]   <= s6_v_ff;
            for (int j = 1; j < vtv_pkg::SQRT_STEPS; j++) begin
               sq_v_ff[j] <= sq_v_ff[j-1];
            end
            dv_v_ff[0]   <= sq_v_ff[vtv_pkg::SQRT_STEPS-1];
            for (int i = 1; i < vtv_pkg::VQ_BITS; i++) begin
               dv_v_ff[i] <= dv_v_ff[i-1];
            end
            out_valid_ff <= dv_v_ff[vtv_pkg::VQ_BITS-1];
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (adv) begin
         s0_pos_ff  <= s0_pos_in;
         s0_nrm_ff  <= s0_nrm_in;
         s1_pp_ff   <= s1_pp_in;
         s1_np_ff   <= s1_np_in;
         s2_ps_ff   <= s2_ps_in;
         s2_na_ff   <= s2_na_in;
         s2_nb_ff   <= s2_nb_in;
         s3_clip_ff <= s3_clip_in;
         s3_tn_ff   <= s3_tn_in;
         s4_nx_ff   <= s4_nx_in;
         s4_ny_ff   <= s4_ny_in;
         s4_sq_ff   <= s4_sq_in;
         s4_cz_ff   <= s4_cz_in;
         s4_cw_ff   <= s4_cw_in;
         s4_tn_ff   <= s4_tn_in;
         s4_wz_ff   <= s4_wz_in;
         s5_c_ff    <= s5_c_in;
         s5_ssum_ff <= s5_ssum_in;
         s6_c_ff    <= s6_c_in;
         s6_ssum_ff <= s5_ssum_ff;
         sq_c_ff    <= sq_c_in;
         sq_rem_ff  <= sq_rem_in;
         sq_res_ff  <= sq_res_in;
         dv_c_ff    <= dv_c_in;
         dv_len_ff  <= dv_len_in;
         dv_rem_ff  <= dv_rem_in;
         dv_q_ff    <= dv_q_in;
         out_data_ff <= out_data_in;
         out_flag_ff <= out_flag_in;
      end
   end

endmodule
